// ===== sv/bsps_pkg.sv =====
package bsps_pkg;

    localparam int MAX_FACES  = 1024;
    localparam int COORD_BITS = 16;

    localparam int IDX_BITS   = $clog2(MAX_FACES);
    localparam int CNT_BITS   = $clog2(MAX_FACES + 1);
    localparam int EDGE_BITS  = COORD_BITS + 1;
    localparam int NORM_BITS  = 2 * COORD_BITS + 2;
    localparam int SUM_BITS   = COORD_BITS + 2;
    localparam int DIFF_BITS  = SUM_BITS + 1;
    localparam int PROD_BITS  = DIFF_BITS + NORM_BITS;
    localparam int DOT_BITS   = PROD_BITS + 2;
    localparam int ACC_BITS   = CNT_BITS + 1;
    localparam int OUT_BITS   = 10;
    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vertex_a_x;
        logic signed [COORD_BITS-1:0] vertex_a_y;
        logic signed [COORD_BITS-1:0] vertex_a_z;
        logic signed [COORD_BITS-1:0] vertex_b_x;
        logic signed [COORD_BITS-1:0] vertex_b_y;
        logic signed [COORD_BITS-1:0] vertex_b_z;
        logic signed [COORD_BITS-1:0] vertex_c_x;
        logic signed [COORD_BITS-1:0] vertex_c_y;
        logic signed [COORD_BITS-1:0] vertex_c_z;
        logic                         last_face;
    } t_in_item;

    typedef struct packed {
        logic [OUT_BITS-1:0] best_face_index;
        logic [OUT_BITS-1:0] best_balance_score;
    } t_out_item;

    typedef struct packed {
        logic signed [NORM_BITS-1:0] nx;
        logic signed [NORM_BITS-1:0] ny;
        logic signed [NORM_BITS-1:0] nz;
        logic signed [SUM_BITS-1:0]  sx;
        logic signed [SUM_BITS-1:0]  sy;
        logic signed [SUM_BITS-1:0]  sz;
    } t_face_data;

    typedef struct packed {
        t_face_data data;
        logic       last;
    } t_face_rec;

    localparam int FACE_BITS = $bits(t_face_data);
    localparam int REC_BITS  = $bits(t_face_rec);

endpackage

// ===== sv/bsps_ram.sv =====
module bsps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/bsps_front.sv =====
module bsps_front import bsps_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_in_item  i_item,
    output logic      o_full,
    output logic      o_rec_valid,
    output t_face_rec o_rec,
    input  logic      i_rec_full
);

    // Stage one holds the edge vectors and vertex sums, stage two the six cross products.
    logic                        r_v1, r_v2, n_adv1, n_adv2;
    logic signed [EDGE_BITS-1:0] r_e0x, r_e0y, r_e0z, r_e1x, r_e1y, r_e1z;
    logic signed [SUM_BITS-1:0]  r_s1x, r_s1y, r_s1z, r_s2x, r_s2y, r_s2z;
    logic                        r_l1, r_l2;
    logic signed [NORM_BITS-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;

    always_comb begin
        n_adv2 = !r_v2 || !i_rec_full;
        n_adv1 = !r_v1 || n_adv2;
    end

    assign o_full = !n_adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (n_adv1) begin
                r_v1 <= i_push;
            end
            if (n_adv2) begin
                r_v2 <= r_v1;
            end
        end
        if (n_adv1) begin
            r_e0x <= EDGE_BITS'(i_item.vertex_b_x) - EDGE_BITS'(i_item.vertex_a_x);
            r_e0y <= EDGE_BITS'(i_item.vertex_b_y) - EDGE_BITS'(i_item.vertex_a_y);
            r_e0z <= EDGE_BITS'(i_item.vertex_b_z) - EDGE_BITS'(i_item.vertex_a_z);
            r_e1x <= EDGE_BITS'(i_item.vertex_c_x) - EDGE_BITS'(i_item.vertex_a_x);
            r_e1y <= EDGE_BITS'(i_item.vertex_c_y) - EDGE_BITS'(i_item.vertex_a_y);
            r_e1z <= EDGE_BITS'(i_item.vertex_c_z) - EDGE_BITS'(i_item.vertex_a_z);
            r_s1x <= SUM_BITS'(i_item.vertex_a_x) + SUM_BITS'(i_item.vertex_b_x)
                   + SUM_BITS'(i_item.vertex_c_x);
            r_s1y <= SUM_BITS'(i_item.vertex_a_y) + SUM_BITS'(i_item.vertex_b_y)
                   + SUM_BITS'(i_item.vertex_c_y);
            r_s1z <= SUM_BITS'(i_item.vertex_a_z) + SUM_BITS'(i_item.vertex_b_z)
                   + SUM_BITS'(i_item.vertex_c_z);
            r_l1  <= i_item.last_face;
        end
        if (n_adv2) begin
            r_p0  <= r_e0y * r_e1z;
            r_p1  <= r_e0z * r_e1y;
            r_p2  <= r_e0z * r_e1x;
            r_p3  <= r_e0x * r_e1z;
            r_p4  <= r_e0x * r_e1y;
            r_p5  <= r_e0y * r_e1x;
            r_s2x <= r_s1x;
            r_s2y <= r_s1y;
            r_s2z <= r_s1z;
            r_l2  <= r_l1;
        end
    end

    // Each difference stays within the normal width since every product is below 2^32.
    always_comb begin
        o_rec_valid  = r_v2;
        o_rec.data.nx = r_p0 - r_p1;
        o_rec.data.ny = r_p2 - r_p3;
        o_rec.data.nz = r_p4 - r_p5;
        o_rec.data.sx = r_s2x;
        o_rec.data.sy = r_s2y;
        o_rec.data.sz = r_s2z;
        o_rec.last    = r_l2;
    end

endmodule

// ===== sv/bsps_fifo.sv =====
module bsps_fifo import bsps_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_face_rec i_data,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_valid,
    output t_face_rec o_data
);

    localparam int PTR_BITS = $clog2(FIFO_DEPTH);

    t_face_rec             r_mem [FIFO_DEPTH];
    logic [PTR_BITS-1:0]   r_wp, r_rp;
    logic [PTR_BITS:0]     r_cnt;
    logic                  n_wr, n_rd;

    always_comb begin
        o_full  = (r_cnt == (PTR_BITS+1)'(FIFO_DEPTH));
        o_valid = (r_cnt != '0);
        n_wr    = i_push && !o_full;
        n_rd    = i_pop && o_valid;
        o_data  = r_mem[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (n_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (n_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (n_wr && !n_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (n_rd && !n_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (n_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== sv/bsps_back.sv =====
module bsps_back import bsps_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_rec_valid,
    input  t_face_rec i_rec,
    output logic      o_rec_pop,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_result
);

    typedef enum logic [5:0] {
        S_LOAD   = 6'b000001,
        S_RD_I   = 6'b000010,
        S_LAT_I  = 6'b000100,
        S_STREAM = 6'b001000,
        S_DRAIN  = 6'b010000,
        S_OUTW   = 6'b100000
    } t_state;

    typedef struct packed {
        logic v;
        logic skip;
        logic fin;
    } t_tag;

    t_state                      r_state;
    logic [CNT_BITS-1:0]         r_cnt, r_n, r_j;
    logic [IDX_BITS-1:0]         r_i, r_best_idx, n_raddr;
    logic [OUT_BITS-1:0]         r_best_score;
    logic                        r_have_best;
    t_face_data                  r_ci, n_rdata;
    t_tag                        r_t0, r_t1, r_t2, n_t0;
    logic                        r_fin;
    logic signed [DIFF_BITS-1:0] r_dx, r_dy, r_dz;
    logic signed [PROD_BITS-1:0] r_mx, r_my, r_mz;
    logic signed [DOT_BITS-1:0]  n_dot;
    logic signed [ACC_BITS-1:0]  r_acc;
    logic [ACC_BITS-1:0]         n_abs;
    logic [OUT_BITS-1:0]         n_score;
    logic                        n_we, r_out_valid;
    t_out_item                   r_out;

    bsps_ram #(.WIDTH(FACE_BITS), .DEPTH(MAX_FACES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (r_cnt[IDX_BITS-1:0]),
        .i_wdata (i_rec.data),
        .i_raddr (n_raddr),
        .o_rdata (n_rdata)
    );

    always_comb begin
        o_rec_pop = (r_state == S_LOAD) && i_rec_valid;
        n_we      = o_rec_pop && (r_cnt < CNT_BITS'(MAX_FACES));
        n_raddr   = (r_state == S_STREAM) ? r_j[IDX_BITS-1:0] : r_i;
        n_dot     = DOT_BITS'(r_mx) + DOT_BITS'(r_my) + DOT_BITS'(r_mz);
        n_abs     = r_acc[ACC_BITS-1] ? ACC_BITS'(-r_acc) : ACC_BITS'(r_acc);
        n_score   = n_abs[OUT_BITS-1:0];
        o_empty   = !r_out_valid;
        o_result  = r_out;
        n_t0      = '0;
        if (r_state == S_STREAM) begin
            n_t0.v    = 1'b1;
            n_t0.skip = (r_j[IDX_BITS-1:0] == r_i);
            n_t0.fin  = (r_j == r_n - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_t0        <= '0;
            r_t1        <= '0;
            r_t2        <= '0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_t0  <= n_t0;
            r_t1  <= r_t0;
            r_t2  <= r_t1;
            r_fin <= r_t2.v && r_t2.fin;
            if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (o_rec_pop) begin
                        if (i_rec.last) begin
                            r_n     <= r_cnt + CNT_BITS'(n_we);
                            r_cnt   <= '0;
                            r_i     <= '0;
                            r_have_best <= 1'b0;
                            r_state <= S_RD_I;
                        end else if (n_we) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                S_RD_I: begin
                    r_state <= S_LAT_I;
                end
                S_LAT_I: begin
                    r_ci    <= n_rdata;
                    r_j     <= '0;
                    r_acc   <= '0;
                    r_state <= S_STREAM;
                end
                S_STREAM: begin
                    r_j <= r_j + 1'b1;
                    if (r_j == r_n - 1'b1) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_fin) begin
                        if (!r_have_best || n_score < r_best_score) begin
                            r_have_best  <= 1'b1;
                            r_best_score <= n_score;
                            r_best_idx   <= r_i;
                        end
                        if (CNT_BITS'(r_i) == r_n - 1'b1) begin
                            r_state <= S_OUTW;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_RD_I;
                        end
                    end
                end
                S_OUTW: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
            if (r_t2.v && !r_t2.skip) begin
                r_acc <= n_dot[DOT_BITS-1] ? r_acc - 1'b1 : r_acc + 1'b1;
            end
        end
        // Payload of the compare pipeline: centroid offsets, then products with the normal.
        r_dx <= DIFF_BITS'(n_rdata.sx) - DIFF_BITS'(r_ci.sx);
        r_dy <= DIFF_BITS'(n_rdata.sy) - DIFF_BITS'(r_ci.sy);
        r_dz <= DIFF_BITS'(n_rdata.sz) - DIFF_BITS'(r_ci.sz);
        r_mx <= r_dx * r_ci.nx;
        r_my <= r_dy * r_ci.ny;
        r_mz <= r_dz * r_ci.nz;
        if (r_state == S_OUTW && !r_out_valid) begin
            r_out.best_face_index    <= OUT_BITS'(r_best_idx);
            r_out.best_balance_score <= r_best_score;
        end
    end

endmodule

// ===== sv/bsp_split_plane_select.sv =====
// Path: an accepted item passes the front stages and the queue before the back stores it;
// the result of a set of n faces is registered once its last candidate pass has drained.
// Throughput: one item per cycle while loading and o_full is low; evaluation runs n candidate
// passes over the single face memory read port, each pass reading one face a cycle.
// Reset: synchronous, active low; clears the face count, queues and result valid flag; the
// face memory needs no clearing pass since only entries already written are read.
module bsp_split_plane_select import bsps_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_in_item  i_item,
    output logic      o_full,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_result
);

    // The front computes each face's normal and vertex sum in two registered stages.
    // A short queue lets loading continue while the back is busy evaluating a set.
    t_face_rec w_front_rec, w_fifo_rec;
    logic      w_front_valid, w_fifo_full, w_fifo_valid, w_fifo_pop;

    bsps_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_item      (i_item),
        .o_full      (o_full),
        .o_rec_valid (w_front_valid),
        .o_rec       (w_front_rec),
        .i_rec_full  (w_fifo_full)
    );

    bsps_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_data  (w_front_rec),
        .o_full  (w_fifo_full),
        .i_pop   (w_fifo_pop),
        .o_valid (w_fifo_valid),
        .o_data  (w_fifo_rec)
    );

    // The back stores faces and, on the final one, scores every candidate plane by
    // streaming all faces through a sign-of-dot-product pipeline.
    bsps_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (w_fifo_valid),
        .i_rec       (w_fifo_rec),
        .o_rec_pop   (w_fifo_pop),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_result    (o_result)
    );

endmodule

// ===== dv/bsp_checker.sv =====
module bsp_checker import bsps_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  logic      i_full,
    input  t_in_item  i_item,
    input  logic      i_pop,
    input  logic      i_empty,
    input  t_out_item i_result,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Per-face plane data, kept at full precision so the dot product is exact.
    longint    norm_x[MAX_FACES];
    longint    norm_y[MAX_FACES];
    longint    norm_z[MAX_FACES];
    longint    vsum_x[MAX_FACES];
    longint    vsum_y[MAX_FACES];
    longint    vsum_z[MAX_FACES];
    int        stored_faces;
    t_out_item split_queue[$];

    task automatic report(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    function automatic t_out_item pick_split(input int n);
        int        count;
        int        score;
        int        best_score;
        int        best_idx;
        longint    dot;
        t_out_item res;
        best_score = -1;
        best_idx   = 0;
        for (int i = 0; i < n; i++) begin
            count = 0;
            for (int j = 0; j < n; j++) begin
                if (j != i) begin
                    dot = (vsum_x[j] - vsum_x[i]) * norm_x[i]
                        + (vsum_y[j] - vsum_y[i]) * norm_y[i]
                        + (vsum_z[j] - vsum_z[i]) * norm_z[i];
                    count += (dot < 0) ? -1 : 1;
                end
            end
            score = (count < 0) ? -count : count;
            if (best_score < 0 || score < best_score) begin
                best_score = score;
                best_idx   = i;
            end
        end
        if (best_score < 0) best_score = 0;
        res.best_face_index    = best_idx[OUT_BITS-1:0];
        res.best_balance_score = best_score[OUT_BITS-1:0];
        return res;
    endfunction

    task automatic store_face(input t_in_item t);
        longint e0x, e0y, e0z, e1x, e1y, e1z;
        e0x = longint'(t.vertex_b_x) - longint'(t.vertex_a_x);
        e0y = longint'(t.vertex_b_y) - longint'(t.vertex_a_y);
        e0z = longint'(t.vertex_b_z) - longint'(t.vertex_a_z);
        e1x = longint'(t.vertex_c_x) - longint'(t.vertex_a_x);
        e1y = longint'(t.vertex_c_y) - longint'(t.vertex_a_y);
        e1z = longint'(t.vertex_c_z) - longint'(t.vertex_a_z);
        // A full store silently drops the face, but a final flag still closes the set.
        if (stored_faces < MAX_FACES) begin
            norm_x[stored_faces] = e0y * e1z - e0z * e1y;
            norm_y[stored_faces] = e0z * e1x - e0x * e1z;
            norm_z[stored_faces] = e0x * e1y - e0y * e1x;
            vsum_x[stored_faces] = longint'(t.vertex_a_x) + t.vertex_b_x + t.vertex_c_x;
            vsum_y[stored_faces] = longint'(t.vertex_a_y) + t.vertex_b_y + t.vertex_c_y;
            vsum_z[stored_faces] = longint'(t.vertex_a_z) + t.vertex_b_z + t.vertex_c_z;
            stored_faces++;
        end
        if (t.last_face) begin
            split_queue.push_back(pick_split(stored_faces));
            stored_faces = 0;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        stored_faces = 0;
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_push && !i_full) store_face(i_item);
            if (i_pop && !i_empty) begin
                if (split_queue.size() == 0) begin
                    report("unexpected result count", 1, 0);
                end else begin
                    want = split_queue.pop_front();
                    if (i_result.best_face_index !== want.best_face_index)
                        report("best_face_index", i_result.best_face_index,
                               want.best_face_index);
                    if (i_result.best_balance_score !== want.best_balance_score)
                        report("best_balance_score", i_result.best_balance_score,
                               want.best_balance_score);
                end
            end
            o_pending = split_queue.size();
        end
    end
endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    import bsps_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Triangle flavors used when building sets.
    typedef enum int {TRI_WIDE, TRI_NARROW, TRI_FLAT, TRI_MAX, TRI_MIN} t_tri_kind;

    logic      clk;
    logic      rst_n;
    logic      push;
    t_in_item  item;
    logic      full;
    logic      empty;
    logic      pop;
    t_out_item result;
    int        fail_count;
    int        pending;

    // The receiver honors this long hold-off, which lets the result side back up.
    int        pop_hold;
    // No random gaps on either side once this is set.
    bit        calm;
    int        items_sent;

    bsp_split_plane_select dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_push   (push),
        .i_item   (item),
        .o_full   (full),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_result (result)
    );

    bsp_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_item       (item),
        .i_pop        (pop),
        .i_empty      (empty),
        .i_result     (result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Hard limit, far above what the largest sets of the run need to evaluate.
    initial begin
        #20_000_000;
        $display("** bsp_split_plane_select: FAILED **");
        $finish;
    end

    // Builds one triangle. Narrow coordinates make coplanar centroids and ties likely,
    // and flat triangles have a zero normal, so every other face counts as front.
    function automatic t_in_item make_tri(input t_tri_kind kind, input bit last);
        t_in_item t;
        logic [COORD_BITS-1:0] v[9];
        for (int k = 0; k < 9; k++) begin
            case (kind)
                TRI_WIDE:   v[k] = COORD_BITS'($urandom);
                TRI_NARROW: v[k] = COORD_BITS'($urandom_range(0, 8) - 4);
                TRI_MAX:    v[k] = {1'b0, {(COORD_BITS-1){1'b1}}};
                TRI_MIN:    v[k] = {1'b1, {(COORD_BITS-1){1'b0}}};
                default:    v[k] = (k < 3) ? COORD_BITS'($urandom) : v[k-3];
            endcase
        end
        t = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], last};
        return t;
    endfunction

    // Offers one item and returns after the edge that accepts it.
    task automatic send(input t_in_item t);
        if (!calm && $urandom_range(0, 5) == 0) begin
            push = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        push = 1'b1;
        item = t;
        do @(posedge clk); while (full);
        items_sent++;
        @(negedge clk);
        push = 1'b0;
    endtask

    // A whole set of n faces of random flavors, the final one flagged.
    task automatic send_set(input int n);
        t_tri_kind kind;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: kind = TRI_WIDE;
                4, 5, 6, 7: kind = TRI_NARROW;
                default:    kind = TRI_FLAT;
            endcase
            send(make_tri(kind, k == n - 1));
        end
    endtask

    // Receiver: random stall bursts, plus the long hold-off when one is requested.
    initial begin
        int gap;
        pop = 1'b0;
        gap = 0;
        forever begin
            @(negedge clk);
            if (pop_hold > 0) begin
                pop = 1'b0;
                pop_hold--;
            end else if (gap > 0) begin
                pop = 1'b0;
                gap--;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                pop = 1'b0;
                gap = $urandom_range(0, 4);
            end else begin
                pop = 1'b1;
            end
        end
    end

    initial begin
        int set_size;
        push       = 1'b0;
        item       = '0;
        pop_hold   = 0;
        calm       = 1'b0;
        items_sent = 0;
        rst_n      = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Two single face sets, built from the extreme coordinates.
        send(make_tri(TRI_MAX, 1'b1));
        send(make_tri(TRI_MIN, 1'b1));
        // A mix of extremes with a flat triangle among them.
        send(make_tri(TRI_MAX, 1'b0));
        send(make_tri(TRI_FLAT, 1'b0));
        send(make_tri(TRI_MIN, 1'b0));
        send(make_tri(TRI_WIDE, 1'b1));
        // All faces flat: every score is the number of other faces, so index zero wins.
        send(make_tri(TRI_FLAT, 1'b0));
        send(make_tri(TRI_FLAT, 1'b0));
        send(make_tri(TRI_FLAT, 1'b1));
        // Two small sets where equal scores are very likely, so the lower index must win.
        for (int k = 0; k < 4; k++) send(make_tri(TRI_NARROW, k == 3));
        for (int k = 0; k < 6; k++) send(make_tri(TRI_NARROW, k == 5));

        // The sender pauses here until every result is out.
        wait (pending == 0);
        @(negedge clk);

        // Long receiver hold-off while single face sets keep coming, so the block backs up
        // and has to stall its input.
        pop_hold = 600;
        for (int k = 0; k < 30; k++) send(make_tri(TRI_WIDE, 1'b1));

        // Random sets, mostly small with a few larger ones.
        while (items_sent < 580) begin
            if (items_sent > 500) calm = 1'b1;
            set_size = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 48)
                                                    : $urandom_range(1, 10);
            send_set(set_size);
        end

        wait (pending == 0);
        repeat (200) @(posedge clk);
        if (fail_count == 0) begin
            $display("** bsp_split_plane_select: PASSED **");
        end else begin
            $display("** bsp_split_plane_select: FAILED **");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
sv/bsps_pkg.sv
sv/bsps_ram.sv
sv/bsps_front.sv
sv/bsps_fifo.sv
sv/bsps_back.sv
sv/bsp_split_plane_select.sv
dv/bsp_checker.sv
dv/tb_top.sv
